// ----- rtl/core/cli_pkg.sv -----
`timescale 1ns / 1ps

package cli_pkg;

  // Bus operation codes carried in s_tuser
  localparam logic [2:0] OpTick    = 3'd0;
  localparam logic [2:0] OpRead32  = 3'd1;
  localparam logic [2:0] OpRead8   = 3'd2;
  localparam logic [2:0] OpWrite32 = 3'd3;
  localparam logic [2:0] OpWrite8  = 3'd4;
  localparam logic [2:0] OpWrite64 = 3'd5;

  // Word offsets within the register window
  localparam logic [31:0] OffSoft   = 32'h0000_0000;
  localparam logic [31:0] OffCmpLo  = 32'h0000_4000;
  localparam logic [31:0] OffCmpHi  = 32'h0000_4004;
  localparam logic [31:0] OffTimeLo = 32'h0000_BFF8;
  localparam logic [31:0] OffTimeHi = 32'h0000_BFFC;

  localparam logic [31:0] ResetBase = 32'h0200_0000;
  localparam logic [63:0] CmpReset  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] write_data;
    logic [31:0] address;
  } item_t;

  typedef struct packed {
    logic        access_error;
    logic        timer_irq;
    logic        soft_irq;
    logic [31:0] read_data;
  } result_t;

endpackage

// ----- rtl/core/cli_stage.sv -----
`timescale 1ns / 1ps

module cli_stage #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [WIDTH-1:0] m_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  // Take a new word when empty, or whenever the held one leaves in the same cycle
  assign s_ready = !valid || m_ready;
  assign m_valid = valid;
  assign m_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      valid <= 1'b1;
    end else if (m_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data <= s_data;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !m_ready |=> valid && $stable(data))
    else $error("stage dropped or changed a stalled word");

endmodule

// ----- rtl/core/cli_core.sv -----
`timescale 1ns / 1ps

module cli_core #(
  parameter int WINDOW_SIZE = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              fire,
  input  cli_pkg::item_t    item,
  output cli_pkg::result_t  result
);

  typedef struct packed {
    logic        soft_bit;
    logic [63:0] cmp;
    logic [63:0] tcount;
    logic        pending;
    logic        update_due;
    logic        cmp_high_done;
    logic        suspended;
    logic        line;
  } state_t;

  logic [31:0] window_base;
  state_t      st;
  state_t      st_next;

  logic [31:0] off;
  logic [32:0] off_hi;
  logic        in_win;
  logic        in_win_hi;
  logic [31:0] woff;
  logic [31:0] woff_hi;
  logic [4:0]  shift;
  logic [31:0] word;
  logic [31:0] merged;
  logic [31:0] rd;
  logic        err;
  logic        now;

  function automatic logic is_mapped(logic [31:0] w);
    return (w == cli_pkg::OffSoft) || (w == cli_pkg::OffCmpLo) ||
           (w == cli_pkg::OffCmpHi) || (w == cli_pkg::OffTimeLo) ||
           (w == cli_pkg::OffTimeHi);
  endfunction

  function automatic logic [31:0] word_get(state_t s, logic [31:0] w);
    logic [31:0] v;
    unique case (w)
      cli_pkg::OffSoft:   v = {31'b0, s.soft_bit};
      cli_pkg::OffCmpLo:  v = s.cmp[31:0];
      cli_pkg::OffCmpHi:  v = s.cmp[63:32];
      cli_pkg::OffTimeLo: v = s.tcount[31:0];
      cli_pkg::OffTimeHi: v = s.tcount[63:32];
      default:            v = 32'b0;
    endcase
    return v;
  endfunction

  function automatic state_t reeval(state_t s);
    state_t r;
    logic   hit;
    r   = s;
    hit = r.tcount >= r.cmp;
    if (hit != r.pending) begin
      r.pending    = hit;
      r.update_due = 1'b1;
    end
    return r;
  endfunction

  function automatic state_t word_put(state_t s, logic [31:0] w, logic [31:0] d);
    state_t r;
    r = s;
    unique case (w)
      cli_pkg::OffSoft: r.soft_bit = d[0];
      cli_pkg::OffCmpLo: begin
        r.cmp[31:0] = d;
        // a compare update counts only once both halves are in
        if (r.cmp_high_done) begin
          r.cmp_high_done = 1'b0;
          r = reeval(r);
        end
      end
      cli_pkg::OffCmpHi: begin
        r.cmp[63:32]    = d;
        r.cmp_high_done = 1'b1;
      end
      cli_pkg::OffTimeLo: begin
        r.tcount[31:0] = d;
        r.suspended    = 1'b0;
        r = reeval(r);
      end
      cli_pkg::OffTimeHi: begin
        r.suspended     = 1'b1;
        r.tcount[63:32] = d;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Address decode: no wrap at 32 bits on either the base or the upper half
  assign off       = item.address - window_base;
  assign in_win    = (item.address >= window_base) && (off < 32'(WINDOW_SIZE));
  assign off_hi    = {1'b0, off} + 33'd4;
  assign in_win_hi = in_win && (off_hi < 33'(WINDOW_SIZE));
  assign woff      = {off[31:2], 2'b00};
  assign woff_hi   = {off_hi[31:2], 2'b00};
  assign shift     = {off[1:0], 3'b000};

  always_comb begin
    st_next = st;
    rd      = 32'b0;
    err     = 1'b0;
    word    = 32'b0;
    merged  = 32'b0;
    now     = 1'b0;
    case (item.op)
      cli_pkg::OpTick: begin
        if (!st_next.suspended) begin
          st_next.tcount = st_next.tcount + 64'd1;
        end
        if (st_next.update_due) begin
          st_next.update_due = 1'b0;
          st_next.line       = st_next.pending;
        end
        now = st_next.tcount >= st_next.cmp;
        if (now != st_next.pending) begin
          st_next.pending = now;
          st_next.line    = now;
        end
      end
      cli_pkg::OpRead32: begin
        if (in_win) begin
          rd  = word_get(st, woff);
          err = !is_mapped(woff);
        end else begin
          err = 1'b1;
        end
      end
      cli_pkg::OpRead8: begin
        if (in_win) begin
          word = word_get(st, woff);
          rd   = (word >> shift) & 32'h0000_00FF;
          err  = !is_mapped(woff);
        end else begin
          err = 1'b1;
        end
      end
      cli_pkg::OpWrite32: begin
        if (in_win) begin
          st_next = word_put(st, woff, item.write_data[31:0]);
          err     = !is_mapped(woff);
        end else begin
          err = 1'b1;
        end
      end
      cli_pkg::OpWrite8: begin
        if (in_win) begin
          // hold the counter across the read-modify-write of a time byte
          if ((woff == cli_pkg::OffTimeLo) || (woff == cli_pkg::OffTimeHi)) begin
            st_next.suspended = 1'b1;
          end
          word    = word_get(st_next, woff);
          merged  = (word & ~(32'h0000_00FF << shift)) |
                    ({24'b0, item.write_data[7:0]} << shift);
          st_next = word_put(st_next, woff, merged);
          if ((woff == cli_pkg::OffTimeLo) && (off[1:0] == 2'b00)) begin
            st_next.suspended = 1'b0;
          end
          err = !is_mapped(woff);
        end else begin
          err = 1'b1;
        end
      end
      cli_pkg::OpWrite64: begin
        if (!in_win) begin
          err = 1'b1;
        end else if ((off == cli_pkg::OffCmpLo) || (off == cli_pkg::OffTimeLo)) begin
          // high word first so the low write completes the update
          st_next = word_put(st, woff_hi, item.write_data[63:32]);
          st_next = word_put(st_next, woff, item.write_data[31:0]);
        end else begin
          st_next = word_put(st, woff, item.write_data[31:0]);
          err     = !is_mapped(woff);
          if (in_win_hi) begin
            st_next = word_put(st_next, woff_hi, item.write_data[63:32]);
            err     = err || !is_mapped(woff_hi);
          end else begin
            err = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result.read_data    = rd;
  assign result.soft_irq     = st_next.soft_bit;
  assign result.timer_irq    = st_next.line;
  assign result.access_error = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= cli_pkg::ResetBase;
    end else if (cfg_we) begin
      window_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.soft_bit      <= 1'b0;
      st.cmp           <= cli_pkg::CmpReset;
      st.tcount        <= 64'b0;
      st.pending       <= 1'b0;
      st.update_due    <= 1'b0;
      st.cmp_high_done <= 1'b0;
      st.suspended     <= 1'b0;
      st.line          <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> st == $past(st))
    else $error("register state changed without a word");

  a_tick_sync: assert property (@(posedge clk) disable iff (rst)
    fire && (item.op == cli_pkg::OpTick) |=> (st.line == st.pending) && !st.update_due)
    else $error("timer line out of step with pending after a tick");

  a_suspend: assert property (@(posedge clk) disable iff (rst)
    fire && (item.op == cli_pkg::OpTick) && st.suspended |=> st.tcount == $past(st.tcount))
    else $error("time counter advanced while suspended");

endmodule

// ----- rtl/core/core_local_interruptor.sv -----
`timescale 1ns / 1ps
// A word accepted on s_* passes through the input register, then the result
// register, before it is presented on m_*.
// Throughput: one word per cycle unless m_tready stalls the output. The register
// update (64-bit counter increment and compare) lies between input and result stages.
// Reset (rst, synchronous): window base 0x0200_0000, compare all ones,
// counter, soft bit and interrupt flags cleared, both stages emptied.

module core_local_interruptor #(
  parameter int WINDOW_SIZE = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // address[31:0], write_data[95:32]
  input  logic [2:0]  s_tuser,   // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_data[31:0], soft_irq[32], timer_irq[33], zero fill
  output logic        m_tuser    // access_error[0]
);

  cli_pkg::item_t   s_item;
  cli_pkg::item_t   in_item;
  cli_pkg::result_t res;
  cli_pkg::result_t out_res;

  logic [$bits(cli_pkg::item_t)-1:0]   in_bits;
  logic [$bits(cli_pkg::result_t)-1:0] out_bits;
  logic                                in_valid;
  logic                                out_ready;

  assign s_item.op         = s_tuser;
  assign s_item.address    = s_tdata[31:0];
  assign s_item.write_data = s_tdata[95:32];

  cli_stage #(
    .WIDTH($bits(cli_pkg::item_t))
  ) u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_data  (s_item),
    .m_valid (in_valid),
    .m_ready (out_ready),
    .m_data  (in_bits)
  );

  assign in_item = cli_pkg::item_t'(in_bits);

  cli_core #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (in_valid && out_ready),
    .item      (in_item),
    .result    (res)
  );

  cli_stage #(
    .WIDTH($bits(cli_pkg::result_t))
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .s_valid (in_valid),
    .s_ready (out_ready),
    .s_data  (res),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (out_bits)
  );

  assign out_res = cli_pkg::result_t'(out_bits);
  assign m_tdata = {6'b0, out_res.timer_irq, out_res.soft_irq, out_res.read_data};
  assign m_tuser = out_res.access_error;

endmodule
